// ===== design/slt_pkg.sv =====
// Shared constants, types and helpers for the sorted leaf table.
package slt_pkg;

  localparam int MAX_CELLS = 16;
  localparam int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 64;
  localparam int POS_W     = 5;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wkey;
    logic [VAL_W-1:0] wval;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             status;
    logic [POS_W-1:0] cell_count;
  } result_t;

  function automatic logic [POS_W-1:0] fit_pos(input logic [CNT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[POS_W-1:0];
  endfunction

endpackage

// ===== design/sorted_leaf_table_core.sv =====
// Top level of the sorted leaf table: key and value memories, sequencer, output register.
// A find runs a binary search over the key memory with its registered read; an insert then
// shifts each cell above the insert position up by one and writes the new key and value.
// A clear or an unused command goes straight to the result. One item is worked on at a time.
// The result sits in an output register, so the next item is taken while it waits.
// Reset empties the node at once; the memories are not cleared and need no clearing pass.
module sorted_leaf_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [slt_pkg::CMD_W-1:0] cmd,
  input  logic [slt_pkg::KEY_W-1:0] key,
  input  logic [slt_pkg::VAL_W-1:0] value_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [slt_pkg::POS_W-1:0] position,
  output logic                      found,
  output logic [slt_pkg::VAL_W-1:0] value_out,
  output logic                      status,
  output logic [slt_pkg::POS_W-1:0] cell_count
);

  slt_pkg::mem_req_t         mem_req;
  slt_pkg::result_t          res;
  slt_pkg::result_t          out_q;
  logic                      res_valid;
  logic                      res_ready;
  logic [slt_pkg::KEY_W-1:0] rd_key;
  logic [slt_pkg::VAL_W-1:0] rd_value;

  slt_ram #(
    .WIDTH  (slt_pkg::KEY_W),
    .DEPTH  (slt_pkg::MAX_CELLS),
    .ADDR_W (slt_pkg::IDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wkey),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_key)
  );

  slt_ram #(
    .WIDTH  (slt_pkg::VAL_W),
    .DEPTH  (slt_pkg::MAX_CELLS),
    .ADDR_W (slt_pkg::IDX_W)
  ) u_value_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wval),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_value)
  );

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .key       (key),
    .value_in  (value_in),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      out_q     <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign position   = out_q.position;
  assign found      = out_q.found;
  assign value_out  = out_q.value_out;
  assign status     = out_q.status;
  assign cell_count = out_q.cell_count;

endmodule

// ===== design/slt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module slt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/slt_ctrl.sv =====
// Command sequencer: binary search, cell shift and result formation.
module slt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [slt_pkg::CMD_W-1:0] cmd,
  input  logic [slt_pkg::KEY_W-1:0] key,
  input  logic [slt_pkg::VAL_W-1:0] value_in,
  input  logic [slt_pkg::KEY_W-1:0] rd_key,
  input  logic [slt_pkg::VAL_W-1:0] rd_value,
  output slt_pkg::mem_req_t         mem_req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output slt_pkg::result_t          res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_RESOLVE,
    ST_SHIFT,
    ST_INS,
    ST_DONE
  } state_t;

  state_t                      state;
  logic [slt_pkg::CMD_W-1:0]   cmd_q;
  logic [slt_pkg::KEY_W-1:0]   key_q;
  logic [slt_pkg::VAL_W-1:0]   val_q;
  logic [slt_pkg::CNT_W-1:0]   count;
  logic [slt_pkg::CNT_W-1:0]   lo;
  logic [slt_pkg::CNT_W-1:0]   hi;
  logic [slt_pkg::CNT_W-1:0]   mid;
  logic [slt_pkg::CNT_W-1:0]   pos;
  logic                        hit;
  logic [slt_pkg::VAL_W-1:0]   hit_val;
  logic [slt_pkg::CNT_W-1:0]   widx;
  logic [slt_pkg::CNT_W:0]     mid_sum;
  logic [slt_pkg::CNT_W-1:0]   mid_next;
  logic [slt_pkg::CNT_W-1:0]   count_m1;
  logic [slt_pkg::CNT_W-1:0]   widx_m1;
  logic [slt_pkg::CNT_W-1:0]   widx_m2;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_next  = mid_sum[slt_pkg::CNT_W:1];
  assign count_m1  = count - slt_pkg::CNT_W'(1);
  assign widx_m1   = widx - slt_pkg::CNT_W'(1);
  assign widx_m2   = widx - slt_pkg::CNT_W'(2);
  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    mem_req       = '0;
    mem_req.wkey  = key_q;
    mem_req.wval  = val_q;
    mem_req.waddr = pos[slt_pkg::IDX_W-1:0];
    unique case (state)
      ST_SRCH: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = mid_next[slt_pkg::IDX_W-1:0];
      end
      ST_RESOLVE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = count_m1[slt_pkg::IDX_W-1:0];
      end
      ST_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = widx[slt_pkg::IDX_W-1:0];
        mem_req.wkey  = rd_key;
        mem_req.wval  = rd_value;
        mem_req.re    = 1'b1;
        mem_req.raddr = widx_m2[slt_pkg::IDX_W-1:0];
      end
      ST_INS: begin
        mem_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q         <= cmd;
            key_q         <= key;
            val_q         <= value_in;
            lo            <= '0;
            hi            <= count;
            res.position  <= '0;
            res.found     <= 1'b0;
            res.value_out <= '0;
            res.status    <= 1'b0;
            if (cmd == slt_pkg::CMD_CLEAR) begin
              count          <= '0;
              res.cell_count <= '0;
              state          <= ST_DONE;
            end else if (cmd == slt_pkg::CMD_FIND || cmd == slt_pkg::CMD_INSERT) begin
              state <= ST_SRCH;
            end else begin
              res.cell_count <= slt_pkg::fit_pos(count);
              state          <= ST_DONE;
            end
          end
        end
        ST_SRCH: begin
          if (lo == hi) begin
            pos   <= lo;
            hit   <= 1'b0;
            state <= ST_RESOLVE;
          end else begin
            mid   <= mid_next;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (key_q == rd_key) begin
            pos     <= mid;
            hit     <= 1'b1;
            hit_val <= rd_value;
            state   <= ST_RESOLVE;
          end else begin
            if (key_q < rd_key) begin
              hi <= mid;
            end else begin
              lo <= mid + slt_pkg::CNT_W'(1);
            end
            state <= ST_SRCH;
          end
        end
        ST_RESOLVE: begin
          res.position   <= slt_pkg::fit_pos(pos);
          res.cell_count <= slt_pkg::fit_pos(count);
          if (cmd_q == slt_pkg::CMD_FIND) begin
            res.found     <= hit;
            res.value_out <= hit ? hit_val : '0;
            state         <= ST_DONE;
          end else if (count >= slt_pkg::CNT_W'(slt_pkg::MAX_CELLS)) begin
            res.status <= 1'b1;
            state      <= ST_DONE;
          end else if (count > pos) begin
            widx  <= count;
            state <= ST_SHIFT;
          end else begin
            state <= ST_INS;
          end
        end
        ST_SHIFT: begin
          widx <= widx_m1;
          if (widx_m1 <= pos) begin
            state <= ST_INS;
          end
        end
        ST_INS: begin
          count          <= count + slt_pkg::CNT_W'(1);
          res.cell_count <= slt_pkg::fit_pos(count + slt_pkg::CNT_W'(1));
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
